// ===== src/cltr_pkg.sv =====
`timescale 1ns / 1ps

package cltr_pkg;

	localparam int FUNC_W   = 2;
	localparam int VERTEX_W = 8;
	localparam int CLASS_W  = 6;
	localparam int CAP_W    = 7;

	localparam logic [FUNC_W-1:0] FUNC_MAP    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_EDGE   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REDUCE = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef struct packed {
		logic [CLASS_W-1:0] from_class;
		logic [CLASS_W-1:0] to_class;
	} link_t;

endpackage

// ===== src/class_link_transitive_reducer_core.sv =====
// Map item: written on accept, no stall. Edge item: the held links are scanned for a duplicate
// over the single read port of the link table.
// Reduce item: transitive test walks pairs (j, k) per link through the table read port,
// then each remaining link is emitted, subject to output stalls.
// One item at a time; item_stall is high until the item is finished.
// arst_n clears control, count, overflow and capacity (64); map and table are not cleared.
`timescale 1ns / 1ps

module class_link_transitive_reducer_core #(
	parameter int MAX_VERTICES = 256,
	parameter int MAX_CLASSES  = 64,
	parameter int LINK_DEPTH   = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [cltr_pkg::CAP_W-1:0]      cfg_write_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [cltr_pkg::FUNC_W-1:0]     func,
	input  logic [cltr_pkg::VERTEX_W-1:0]   vertex,
	input  logic [cltr_pkg::CLASS_W-1:0]    class_id,
	input  logic [cltr_pkg::VERTEX_W-1:0]   to_vertex,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [cltr_pkg::CLASS_W-1:0]    src_class,
	output logic [cltr_pkg::CLASS_W-1:0]    dst_class,
	output logic                            link_valid,
	output logic                            last,
	output logic                            overflow
);

	localparam int MAP_DEPTH = (MAX_VERTICES < (1 << cltr_pkg::VERTEX_W)) ?
		MAX_VERTICES : (1 << cltr_pkg::VERTEX_W);
	localparam int MAP_AW  = $clog2(MAP_DEPTH);
	localparam int LINK_AW = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
	localparam int CNT_W   = $clog2(LINK_DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_DUP_RD,
		ST_DUP_CMP,
		ST_RI,
		ST_RI_LD,
		ST_RJ,
		ST_RJ_LD,
		ST_RK,
		ST_RK_CMP,
		ST_REP_RD,
		ST_REP_WR,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_EMPTY
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               link_count_q;
	logic                           overflow_q;
	logic [cltr_pkg::CAP_W-1:0]     cap_q;
	logic [cltr_pkg::VERTEX_W-1:0]  to_vertex_q;
	logic [cltr_pkg::CLASS_W-1:0]   cls_a_q;
	logic [cltr_pkg::CLASS_W-1:0]   cls_b_q;
	logic [CNT_W-1:0]               idx_i_q;
	logic [CNT_W-1:0]               idx_j_q;
	logic [CNT_W-1:0]               idx_k_q;
	cltr_pkg::link_t                link_i_q;
	cltr_pkg::link_t                link_j_q;

	logic                           result_valid_q;
	logic [cltr_pkg::CLASS_W-1:0]   result_start_q;
	logic [cltr_pkg::CLASS_W-1:0]   result_end_q;
	logic                           result_link_q;
	logic                           result_last_q;
	logic                           result_overflow_q;

	logic [cltr_pkg::CLASS_W-1:0]   map_mem [MAP_DEPTH];
	logic [cltr_pkg::CLASS_W-1:0]   map_rd_q;
	cltr_pkg::link_t                link_mem [LINK_DEPTH];
	cltr_pkg::link_t                link_rd_q;

	logic                           item_accept;
	logic                           vertex_ok;
	logic                           to_vertex_ok;
	logic                           class_ok;
	logic                           map_we;
	logic                           map_rd_en;
	logic [MAP_AW-1:0]              map_rd_addr;
	logic                           link_we;
	logic [LINK_AW-1:0]             link_wr_addr;
	cltr_pkg::link_t                link_wr_data;
	logic                           link_rd_en;
	logic [LINK_AW-1:0]             link_rd_addr;
	logic [cltr_pkg::CAP_W-1:0]     eff_cap;
	logic                           table_full;
	logic                           out_free;
	logic                           result_load;
	logic [CNT_W-1:0]               count_m1;

	assign item_stall   = (state_q != ST_IDLE);
	assign item_accept  = item_valid && !item_stall;
	assign vertex_ok    = (32'(vertex) < MAX_VERTICES);
	assign to_vertex_ok = (32'(to_vertex) < MAX_VERTICES);
	assign class_ok     = (32'(class_id) < MAX_CLASSES);
	assign eff_cap      = (32'(cap_q) > LINK_DEPTH) ? cltr_pkg::CAP_W'(LINK_DEPTH) : cap_q;
	assign table_full   = (32'(link_count_q) >= 32'(eff_cap));
	assign out_free     = !result_valid_q || !result_stall;
	assign result_load  = ((state_q == ST_EMIT_LD) || (state_q == ST_EMIT_EMPTY)) && out_free;
	assign count_m1     = link_count_q - CNT_W'(1);

	assign map_we = item_accept && (func == cltr_pkg::FUNC_MAP) && vertex_ok && class_ok;

	always_comb begin
		map_rd_en   = 1'b0;
		map_rd_addr = vertex[MAP_AW-1:0];
		if (state_q == ST_EDGE_A) begin
			map_rd_en   = 1'b1;
			map_rd_addr = to_vertex_q[MAP_AW-1:0];
		end else if (item_accept && (func == cltr_pkg::FUNC_EDGE) && vertex_ok
				&& to_vertex_ok) begin
			map_rd_en = 1'b1;
		end
	end

	always_comb begin
		link_rd_en   = 1'b0;
		link_rd_addr = idx_i_q[LINK_AW-1:0];
		link_we      = 1'b0;
		link_wr_addr = link_count_q[LINK_AW-1:0];
		link_wr_data = '{from_class: cls_a_q, to_class: cls_b_q};
		case (state_q)
			ST_DUP_RD: begin
				link_rd_en   = (idx_k_q != link_count_q);
				link_rd_addr = idx_k_q[LINK_AW-1:0];
				link_we      = (idx_k_q == link_count_q) && !table_full;
			end
			ST_RI: begin
				link_rd_en = (idx_i_q != link_count_q);
			end
			ST_RJ: begin
				link_rd_en   = (idx_j_q != link_count_q);
				link_rd_addr = idx_j_q[LINK_AW-1:0];
			end
			ST_RK: begin
				link_rd_en   = (idx_k_q != link_count_q);
				link_rd_addr = idx_k_q[LINK_AW-1:0];
			end
			ST_REP_RD: begin
				link_rd_en   = 1'b1;
				link_rd_addr = count_m1[LINK_AW-1:0];
			end
			ST_REP_WR: begin
				link_we      = 1'b1;
				link_wr_addr = idx_i_q[LINK_AW-1:0];
				link_wr_data = link_rd_q;
			end
			ST_EMIT_RD: begin
				link_rd_en = 1'b1;
			end
			default: begin
				link_rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[vertex[MAP_AW-1:0]] <= class_id;
		end
		if (map_rd_en) begin
			map_rd_q <= map_mem[map_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wr_addr] <= link_wr_data;
		end
		if (link_rd_en) begin
			link_rd_q <= link_mem[link_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			link_count_q   <= '0;
			overflow_q     <= 1'b0;
			cap_q          <= cltr_pkg::CAP_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				cap_q <= cfg_write_data;
			end
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_accept) begin
						to_vertex_q <= to_vertex;
						idx_i_q     <= '0;
						if ((func == cltr_pkg::FUNC_EDGE) && vertex_ok && to_vertex_ok) begin
							state_q <= ST_EDGE_A;
						end else if (func == cltr_pkg::FUNC_REDUCE) begin
							state_q <= ST_RI;
						end
					end
				end
				ST_EDGE_A: begin
					cls_a_q <= map_rd_q;
					state_q <= ST_EDGE_B;
				end
				ST_EDGE_B: begin
					cls_b_q <= map_rd_q;
					idx_k_q <= '0;
					state_q <= (map_rd_q == cls_a_q) ? ST_IDLE : ST_DUP_RD;
				end
				ST_DUP_RD: begin
					if (idx_k_q == link_count_q) begin
						if (table_full) begin
							overflow_q <= 1'b1;
						end else begin
							link_count_q <= link_count_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DUP_CMP;
					end
				end
				ST_DUP_CMP: begin
					if ((link_rd_q.from_class == cls_a_q) && (link_rd_q.to_class == cls_b_q)) begin
						state_q <= ST_IDLE;
					end else begin
						idx_k_q <= idx_k_q + CNT_W'(1);
						state_q <= ST_DUP_RD;
					end
				end
				ST_RI: begin
					if (idx_i_q == link_count_q) begin
						idx_i_q <= '0;
						state_q <= (link_count_q == '0) ? ST_EMIT_EMPTY : ST_EMIT_RD;
					end else begin
						state_q <= ST_RI_LD;
					end
				end
				ST_RI_LD: begin
					link_i_q <= link_rd_q;
					idx_j_q  <= '0;
					state_q  <= ST_RJ;
				end
				ST_RJ: begin
					if (idx_j_q == link_count_q) begin
						idx_i_q <= idx_i_q + CNT_W'(1);
						state_q <= ST_RI;
					end else begin
						state_q <= ST_RJ_LD;
					end
				end
				ST_RJ_LD: begin
					if ((idx_j_q != idx_i_q) && (link_rd_q.from_class == link_i_q.from_class)) begin
						link_j_q <= link_rd_q;
						idx_k_q  <= '0;
						state_q  <= ST_RK;
					end else begin
						idx_j_q <= idx_j_q + CNT_W'(1);
						state_q <= ST_RJ;
					end
				end
				ST_RK: begin
					if (idx_k_q == link_count_q) begin
						idx_j_q <= idx_j_q + CNT_W'(1);
						state_q <= ST_RJ;
					end else begin
						state_q <= ST_RK_CMP;
					end
				end
				ST_RK_CMP: begin
					if ((idx_k_q != idx_i_q) && (idx_k_q != idx_j_q)
							&& (link_rd_q.from_class == link_j_q.to_class)
							&& (link_rd_q.to_class == link_i_q.to_class)) begin
						state_q <= ST_REP_RD;
					end else begin
						idx_k_q <= idx_k_q + CNT_W'(1);
						state_q <= ST_RK;
					end
				end
				ST_REP_RD: begin
					state_q <= ST_REP_WR;
				end
				ST_REP_WR: begin
					link_count_q <= count_m1;
					state_q      <= ST_RI;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (out_free) begin
						result_start_q    <= link_rd_q.from_class;
						result_end_q      <= link_rd_q.to_class;
						result_link_q     <= 1'b1;
						result_last_q     <= ((idx_i_q + CNT_W'(1)) == link_count_q);
						result_overflow_q <= overflow_q;
						if ((idx_i_q + CNT_W'(1)) == link_count_q) begin
							link_count_q <= '0;
							state_q      <= ST_IDLE;
						end else begin
							idx_i_q <= idx_i_q + CNT_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_EMIT_EMPTY: begin
					if (out_free) begin
						result_start_q    <= '0;
						result_end_q      <= '0;
						result_link_q     <= 1'b0;
						result_last_q     <= 1'b1;
						result_overflow_q <= overflow_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign src_class    = result_start_q;
	assign dst_class    = result_end_q;
	assign link_valid   = result_link_q;
	assign last         = result_last_q;
	assign overflow     = result_overflow_q;

`ifndef SYNTHESIS
	count_in_range_a: assert property (@(posedge clk) disable iff (!arst_n)
		32'(link_count_q) <= LINK_DEPTH)
		else $error("link count above table depth");

	count_step_a: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |=> 32'(link_count_q) <= 32'($past(link_count_q)) + 1)
		else $error("link count grew by more than one");

	overflow_sticky_a: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag cleared without reset");

	empty_is_last_a: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_link_q |-> result_last_q)
		else $error("empty result without last marker");

	idle_after_last_a: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) && result_last_q |-> state_q == ST_IDLE)
		else $error("last result loaded while reduce still running");
`endif

endmodule

// ===== bench/tb_class_link_transitive_reducer_core.sv =====
`timescale 1ns / 1ps

module tb_class_link_transitive_reducer_core;

	localparam int          LINK_DEPTH   = 64;
	localparam int          RANDOM_ITEMS = 340;
	localparam int          SETTLE       = 256;
	localparam int          QUIET_LIMIT  = 8_000_000;
	localparam logic [cltr_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic [cltr_pkg::CLASS_W-1:0] src;
		logic [cltr_pkg::CLASS_W-1:0] dst;
		logic                         carries;
		logic                         tail;
		logic                         sticky;
	} emitted_link_t;

	class link_board;
		logic [cltr_pkg::CLASS_W-1:0] class_of [256];
		cltr_pkg::link_t              links [LINK_DEPTH];
		int unsigned                  held;
		bit                           dropped;
		logic [cltr_pkg::CAP_W-1:0]   capacity;
		emitted_link_t                awaited [$];
		int unsigned                  mismatches;
		int unsigned                  links_checked;

		function new();
			held = 0;
			dropped = 1'b0;
			capacity = cltr_pkg::CAP_RESET;
			mismatches = 0;
			links_checked = 0;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function bit is_shortcut(int unsigned i);
			for (int unsigned j = 0; j < held; j++) begin
				if (j == i || links[j].from_class != links[i].from_class)
					continue;
				for (int unsigned k = 0; k < held; k++) begin
					if (k == i || k == j)
						continue;
					if (links[k].from_class == links[j].to_class &&
					    links[k].to_class == links[i].to_class)
						return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void store_pair(logic [cltr_pkg::CLASS_W-1:0] a,
		                         logic [cltr_pkg::CLASS_W-1:0] b);
			int unsigned room;
			room = (capacity > LINK_DEPTH) ? LINK_DEPTH : capacity;
			for (int unsigned i = 0; i < held; i++)
				if (links[i].from_class == a && links[i].to_class == b)
					return;
			if (held >= room) begin
				dropped = 1'b1;
				return;
			end
			links[held].from_class = a;
			links[held].to_class = b;
			held++;
		endfunction

		function void note_item(logic [cltr_pkg::FUNC_W-1:0] f,
		                        logic [cltr_pkg::VERTEX_W-1:0] v,
		                        logic [cltr_pkg::CLASS_W-1:0] c,
		                        logic [cltr_pkg::VERTEX_W-1:0] t);
			int unsigned i;
			emitted_link_t r;
			case (f)
				cltr_pkg::FUNC_MAP: begin
					class_of[v] = c;
				end
				cltr_pkg::FUNC_EDGE: begin
					if (class_of[v] != class_of[t])
						store_pair(class_of[v], class_of[t]);
				end
				cltr_pkg::FUNC_REDUCE: begin
					i = 0;
					while (i < held) begin
						if (is_shortcut(i)) begin
							links[i] = links[held - 1];
							held--;
						end else begin
							i++;
						end
					end
					if (held == 0) begin
						r = '{src: '0, dst: '0, carries: 1'b0, tail: 1'b1, sticky: dropped};
						awaited.push_back(r);
					end
					for (i = 0; i < held; i++) begin
						r.src = links[i].from_class;
						r.dst = links[i].to_class;
						r.carries = 1'b1;
						r.tail = (i + 1 == held);
						r.sticky = dropped;
						awaited.push_back(r);
					end
					held = 0;
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [cltr_pkg::CLASS_W-1:0] sc,
		                           logic [cltr_pkg::CLASS_W-1:0] ec,
		                           logic lv, logic lst, logic ovf);
			emitted_link_t e;
			if (awaited.size() == 0) begin
				$error("unexpected result: src_class %0d dst_class %0d", sc, ec);
				mismatches++;
				return;
			end
			e = awaited.pop_front();
			links_checked++;
			if (sc !== e.src) begin
				$error("src_class: expected %0d, actual %0d", e.src, sc);
				mismatches++;
			end
			if (ec !== e.dst) begin
				$error("dst_class: expected %0d, actual %0d", e.dst, ec);
				mismatches++;
			end
			if (lv !== e.carries) begin
				$error("link_valid: expected %0d, actual %0d", e.carries, lv);
				mismatches++;
			end
			if (lst !== e.tail) begin
				$error("last: expected %0d, actual %0d", e.tail, lst);
				mismatches++;
			end
			if (ovf !== e.sticky) begin
				$error("overflow: expected %0d, actual %0d", e.sticky, ovf);
				mismatches++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_write_en;
	logic [cltr_pkg::CAP_W-1:0]    cfg_write_data;
	logic                          item_valid;
	logic                          item_stall;
	logic [cltr_pkg::FUNC_W-1:0]   func;
	logic [cltr_pkg::VERTEX_W-1:0] vertex;
	logic [cltr_pkg::CLASS_W-1:0]  class_id;
	logic [cltr_pkg::VERTEX_W-1:0] to_vertex;
	logic                          result_valid;
	logic                          result_stall;
	logic [cltr_pkg::CLASS_W-1:0]  src_class;
	logic [cltr_pkg::CLASS_W-1:0]  dst_class;
	logic                          link_valid;
	logic                          last;
	logic                          overflow;

	link_board                     board = new();
	bit                            steady;
	bit                            result_taken;
	int unsigned                   result_hold;
	int unsigned                   quiet_cycles;
	int unsigned                   items_sent;
	int unsigned                   ignored_sent;
	int unsigned                   caps_written;
	bit                            mapped [256];
	logic [cltr_pkg::VERTEX_W-1:0] known [$];

	class_link_transitive_reducer_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.func          (func),
		.vertex        (vertex),
		.class_id      (class_id),
		.to_vertex     (to_vertex),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.src_class     (src_class),
		.dst_class     (dst_class),
		.link_valid    (link_valid),
		.last          (last),
		.overflow      (overflow)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			board.check_result(src_class, dst_class, link_valid, last, overflow);
			result_taken = 1'b1;
		end
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(negedge clk) begin
		if (result_taken) begin
			result_taken = 1'b0;
			result_hold = steady ? 0 : $urandom_range(0, 3);
		end
		result_stall <= (result_hold != 0);
		if (result_hold != 0 && result_valid)
			result_hold--;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("status: fail");
		$finish;
	end

	task automatic send_item(logic [cltr_pkg::FUNC_W-1:0] f,
	                         logic [cltr_pkg::VERTEX_W-1:0] v,
	                         logic [cltr_pkg::CLASS_W-1:0] c,
	                         logic [cltr_pkg::VERTEX_W-1:0] t);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		func <= f;
		vertex <= v;
		class_id <= c;
		to_vertex <= t;
		do @(posedge clk); while (item_stall);
		board.note_item(f, v, c, t);
		if (f == FUNC_NONE)
			ignored_sent++;
		else
			items_sent++;
		if (f == cltr_pkg::FUNC_MAP && !mapped[v]) begin
			mapped[v] = 1'b1;
			known.push_back(v);
		end
	endtask

	task automatic send_reduce();
		send_item(cltr_pkg::FUNC_REDUCE, 8'($urandom), 6'($urandom), 8'($urandom));
	endtask

	// hold input until all emitted links are back, then let the block settle
	task automatic pause_items();
		@(negedge clk);
		item_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(logic [cltr_pkg::CAP_W-1:0] value);
		pause_items();
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		board.capacity = value;
		caps_written++;
	endtask

	task automatic run_round();
		logic [cltr_pkg::CLASS_W-1:0]  pool [6];
		logic [cltr_pkg::VERTEX_W-1:0] fresh [$];
		logic [cltr_pkg::VERTEX_W-1:0] a;
		logic [cltr_pkg::VERTEX_W-1:0] b;
		int unsigned                   n_pool;
		int unsigned                   n_map;
		int unsigned                   n_edge;
		steady = ($urandom_range(0, 3) == 0);
		n_pool = $urandom_range(2, 6);
		for (int i = 0; i < n_pool; i++)
			pool[i] = 6'($urandom_range(0, 63));
		n_map = $urandom_range(2, 8);
		for (int i = 0; i < n_map; i++) begin
			a = 8'($urandom_range(0, 255));
			send_item(cltr_pkg::FUNC_MAP, a, pool[$urandom_range(0, n_pool - 1)],
			          8'($urandom));
			fresh.push_back(a);
		end
		n_edge = $urandom_range(1, 12);
		for (int i = 0; i < n_edge; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				a = known[$urandom_range(0, known.size() - 1)];
				b = known[$urandom_range(0, known.size() - 1)];
			end else begin
				a = fresh[$urandom_range(0, fresh.size() - 1)];
				b = fresh[$urandom_range(0, fresh.size() - 1)];
			end
			send_item(cltr_pkg::FUNC_EDGE, a, 6'($urandom), b);
			if ($urandom_range(0, 19) == 0)
				send_item(FUNC_NONE, 8'($urandom), 6'($urandom), 8'($urandom));
		end
		if (board.held > 16 || $urandom_range(0, 6) != 0)
			send_reduce();
	endtask

	initial begin
		logic [cltr_pkg::CAP_W-1:0] phase_cap [7];
		int unsigned                start_count;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		item_valid = 1'b0;
		func = cltr_pkg::FUNC_MAP;
		vertex = '0;
		class_id = '0;
		to_vertex = '0;
		result_stall = 1'b0;
		result_taken = 1'b0;
		result_hold = 0;
		quiet_cycles = 0;
		steady = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_item(cltr_pkg::FUNC_MAP, 8'd0, 6'd0, 8'hFF);
		send_item(cltr_pkg::FUNC_MAP, 8'd255, 6'd63, 8'h00);
		send_item(cltr_pkg::FUNC_MAP, 8'd1, 6'd1, 8'hAA);
		send_item(cltr_pkg::FUNC_MAP, 8'd2, 6'd2, 8'h55);
		send_item(cltr_pkg::FUNC_MAP, 8'd170, 6'd42, 8'h0F);
		send_item(cltr_pkg::FUNC_MAP, 8'd85, 6'd21, 8'hF0);
		send_item(cltr_pkg::FUNC_MAP, 8'd3, 6'd1, 8'h00);
		send_reduce();
		send_item(FUNC_NONE, 8'hFF, 6'h3F, 8'hFF);
		send_item(cltr_pkg::FUNC_EDGE, 8'd0, 6'd0, 8'd1);
		send_item(cltr_pkg::FUNC_EDGE, 8'd1, 6'd63, 8'd2);
		send_item(cltr_pkg::FUNC_EDGE, 8'd0, 6'd0, 8'd2);
		send_item(cltr_pkg::FUNC_EDGE, 8'd0, 6'd0, 8'd1);
		send_item(cltr_pkg::FUNC_EDGE, 8'd255, 6'd0, 8'd0);
		send_item(cltr_pkg::FUNC_EDGE, 8'd1, 6'd0, 8'd3);
		send_item(cltr_pkg::FUNC_EDGE, 8'd170, 6'd0, 8'd85);
		send_item(cltr_pkg::FUNC_EDGE, 8'd85, 6'd0, 8'd255);
		send_reduce();

		write_capacity(7'd1);
		send_item(cltr_pkg::FUNC_EDGE, 8'd0, 6'd0, 8'd1);
		send_item(cltr_pkg::FUNC_EDGE, 8'd0, 6'd0, 8'd1);
		send_reduce();
		send_item(cltr_pkg::FUNC_EDGE, 8'd1, 6'd0, 8'd2);
		send_item(cltr_pkg::FUNC_EDGE, 8'd2, 6'd0, 8'd0);
		send_reduce();

		write_capacity(7'd0);
		send_item(cltr_pkg::FUNC_EDGE, 8'd0, 6'd0, 8'd1);
		send_reduce();

		// fill the whole table with a class ring, then push one more link
		write_capacity(7'd127);
		for (int c = 0; c < 64; c++)
			send_item(cltr_pkg::FUNC_MAP, c[7:0], c[5:0], 8'($urandom));
		for (int c = 0; c < 64; c++)
			send_item(cltr_pkg::FUNC_EDGE, c[7:0], 6'($urandom), 8'((c + 1) % 64));
		send_item(cltr_pkg::FUNC_EDGE, 8'd0, 6'd0, 8'd2);
		send_reduce();

		phase_cap = '{7'd2, 7'd64, 7'd127, 7'd1, 7'd5, 7'd1, 7'd64};
		phase_cap[3] = 7'($urandom_range(1, 127));
		phase_cap[6] = 7'($urandom_range(1, 127));
		start_count = items_sent;
		for (int p = 0; p < 7; p++) begin
			write_capacity(phase_cap[p]);
			while (items_sent - start_count < RANDOM_ITEMS * (p + 1) / 7)
				run_round();
			send_reduce();
		end
		pause_items();

		$display("run covered %0d items plus %0d ignored codes over %0d capacity settings;",
		         items_sent, ignored_sent, caps_written);
		$display("%0d emitted links checked, %0d mismatches", board.links_checked,
		         board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
